/* src/irp_pkg.sv */
// shared constants, types and byte-class helpers for the image reference parser
// no dependencies; used by irp_verdict_if and by image_reference_parser
package irp_pkg;

  localparam int MAX_LEN = 4096;
  localparam int MAX_TAG = 128;
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 2);
  localparam int TAG_W   = $clog2(MAX_TAG + 2);
  localparam int OUT_W   = 13;
  localparam int SLEN_W  = 8;
  localparam int HEX_W   = 8;

  localparam logic [HEX_W-1:0]  HEX_SHA256   = 8'd64;
  localparam logic [HEX_W-1:0]  HEX_SHA512   = 8'd128;
  localparam logic [HEX_W-1:0]  HEX_SAT      = 8'd129;
  localparam logic [2:0]        ALGO_CHARS   = 3'd6;
  localparam logic [2:0]        ALGO_SAT     = 3'd7;
  localparam logic [2:0]        PORT_MAX     = 3'd5;
  localparam logic [2:0]        PORT_SAT     = 3'd6;
  localparam logic [SLEN_W-1:0] DIGEST_HEAD  = 8'd7;
  localparam logic [POS_W-1:0]  HOST_CHARS   = POS_W'(9);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    ST_OK, ST_EMPTY, ST_TOO_LONG, ST_MULTI_AT, ST_NO_DIGEST, ST_DIGEST_NO_COLON,
    ST_BAD_ALGO, ST_HEX_COUNT, ST_BAD_HEX, ST_NO_NAME, ST_EMPTY_TAG, ST_BAD_TAG,
    ST_NO_NAME_TAG, ST_NO_REPO, ST_BAD_PATH, ST_BAD_REGISTRY
  } status_t;

  // path component grammar: alnum+ ((. | _ | __ | -+) alnum+)*
  typedef enum logic [2:0] {
    C_START, C_ALNUM, C_DOT, C_US1, C_US2, C_DASH, C_BAD
  } comp_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] pos;
    logic [1:0]       at_cnt;
    logic [POS_W-1:0] at_off;
    logic [1:0]       slash_cnt;
    logic [POS_W-1:0] slash_pos;
    comp_state_t      cs;
    logic             comp0_ok;
    logic             rest_ok;
    logic             tag_seen;
    logic [POS_W-1:0] tag_pos;
    logic [TAG_W-1:0] tag_cnt;
    logic             tag_bad;
    logic             snap_ok;
    logic             snap_empty;
    logic             pre_dc;
    logic             local_ok;
    logic             hub_ok;
    logic             reg_bad;
    logic             reg_colon;
    logic             reg_colon0;
    logic [2:0]       port_cnt;
    logic             port_bad;
    logic             d_any;
    logic             d_colon;
    logic [2:0]       algo_cnt;
    logic             m256;
    logic             m512;
    logic [HEX_W-1:0] hex_cnt;
    logic             hex_bad;
  } scan_t;

  typedef struct packed {
    status_t           status;
    logic [OUT_W-1:0]  reg_size;
    logic [OUT_W-1:0]  repo_off;
    logic [OUT_W-1:0]  repo_size;
    logic [OUT_W-1:0]  tag_start;
    logic [SLEN_W-1:0] tag_len;
    logic [OUT_W-1:0]  dgst_off;
    logic [SLEN_W-1:0] dgst_size;
    logic              digest_sha512;
    logic              add_library_prefix;
    logic              implied_tag;
  } verdict_t;

  function automatic scan_t scan_init();
    scan_t s;
    s = '0;
    s.cs       = C_START;
    s.rest_ok  = 1'b1;
    s.local_ok = 1'b1;
    s.hub_ok   = 1'b1;
    s.m256     = 1'b1;
    s.m512     = 1'b1;
    return s;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_lc_alnum(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_lc_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_lc_alnum(c) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic comp_accept(comp_state_t s);
    return s == C_ALNUM;
  endfunction

  function automatic comp_state_t comp_step(comp_state_t s, logic [7:0] c);
    logic        an;
    comp_state_t r;
    an = is_lc_alnum(c);
    r  = C_BAD;
    unique case (s)
      C_START, C_DOT, C_US2: r = an ? C_ALNUM : C_BAD;
      C_ALNUM: begin
        if (an) r = C_ALNUM;
        else if (c == CH_DASH) r = C_DASH;
        else if (c == CH_UNDER) r = C_US1;
        else if (c == CH_DOT) r = C_DOT;
        else r = C_BAD;
      end
      C_US1:  r = an ? C_ALNUM : (c == CH_UNDER) ? C_US2 : C_BAD;
      C_DASH: r = an ? C_ALNUM : (c == CH_DASH) ? C_DASH : C_BAD;
      default: r = C_BAD;
    endcase
    return r;
  endfunction

  // "localhost"
  function automatic logic [7:0] local_char(logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h6C; 4'd1: r = 8'h6F; 4'd2: r = 8'h63; 4'd3: r = 8'h61;
      4'd4: r = 8'h6C; 4'd5: r = 8'h68; 4'd6: r = 8'h6F; 4'd7: r = 8'h73;
      4'd8: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // default hub host name
  function automatic logic [7:0] hub_char(logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h64; 4'd1: r = 8'h6F; 4'd2: r = 8'h63; 4'd3: r = 8'h6B;
      4'd4: r = 8'h65; 4'd5: r = 8'h72; 4'd6: r = 8'h2E; 4'd7: r = 8'h69;
      4'd8: r = 8'h6F;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "sha256" / "sha512"
  function automatic logic [7:0] algo_char(logic [2:0] i, logic sel512);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h73;
      3'd1: r = 8'h68;
      3'd2: r = 8'h61;
      3'd3: r = sel512 ? 8'h35 : 8'h32;
      3'd4: r = sel512 ? 8'h31 : 8'h35;
      3'd5: r = sel512 ? 8'h32 : 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* src/irp_if.sv */
// valid/ready channels of the image reference parser: input bytes and verdicts
// depends on irp_pkg
interface irp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ref_byte;
  logic       last;
  logic       end_only;
  modport source (output valid, ref_byte, last, end_only, input ready);
  modport sink (input valid, ref_byte, last, end_only, output ready);
endinterface

interface irp_verdict_if import irp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [3:0]        status;
  logic [OUT_W-1:0]  reg_size;
  logic [OUT_W-1:0]  repo_off;
  logic [OUT_W-1:0]  repo_size;
  logic [OUT_W-1:0]  tag_start;
  logic [SLEN_W-1:0] tag_len;
  logic [OUT_W-1:0]  dgst_off;
  logic [SLEN_W-1:0] dgst_size;
  logic              digest_sha512;
  logic              add_library_prefix;
  logic              implied_tag;
  modport source (output valid, status, reg_size, repo_off, repo_size, tag_start,
                  tag_len, dgst_off, dgst_size, digest_sha512, add_library_prefix,
                  implied_tag, input ready);
  modport sink (input valid, status, reg_size, repo_off, repo_size, tag_start,
                tag_len, dgst_off, dgst_size, digest_sha512, add_library_prefix,
                implied_tag, output ready);
endinterface

/* src/image_reference_parser.sv */
// image reference parser top level: byte scanner, verdict logic and output register
// depends on irp_pkg and the channel interfaces in irp_if.sv
//
// Takes one reference byte per cycle with no gaps of its own while the input is not
// stalled: each word passes an input register, then updates a small set of counters and
// flags (component grammar state, tag, registry and digest checks). When a word carries
// last or end_only, the verdict is formed from the updated flags in that same step and
// held in an output register; the final word thus passes the input register and then
// the output register, and may wait in the input register while the output register is
// full. The scan state returns to reset after each verdict. The input only stalls while
// a verdict is waiting in the output register and another reference end is ready to
// leave the input register.
module image_reference_parser import irp_pkg::*; (
  input logic            clk,
  input logic            rst,
  irp_in_if.sink         ref_in,
  irp_verdict_if.source  verdict
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_end_only;
  logic       s1_ends;
  logic       out_free;
  logic       s1_adv;

  scan_t      scan;
  scan_t      scan_next;
  verdict_t   vd;
  verdict_t   vd_next;
  logic       vd_valid;

  logic       in_rng;
  logic       is_at;
  logic       nm;
  logic       dg;
  logic [3:0] idx9;

  assign s1_ends      = s1_end_only || s1_last;
  assign out_free     = !vd_valid || verdict.ready;
  assign s1_adv       = s1_valid && (!s1_ends || out_free);
  assign ref_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ref_in.ready) begin
      s1_valid <= ref_in.valid;
    end
    if (ref_in.ready && ref_in.valid) begin
      s1_byte     <= ref_in.ref_byte;
      s1_last     <= ref_in.last;
      s1_end_only <= ref_in.end_only;
    end
  end

  // byte scan
  always_comb begin
    scan_next = scan;
    in_rng    = scan.pos < LEN_W'(MAX_LEN);
    is_at     = s1_byte == CH_AT;
    nm        = !s1_end_only && in_rng && scan.at_cnt == 2'd0 && !is_at;
    dg        = !s1_end_only && in_rng && scan.at_cnt == 2'd1 && !is_at;
    idx9      = scan.pos[3:0];
    if (!s1_end_only) begin
      if (scan.pos <= LEN_W'(MAX_LEN)) scan_next.pos = scan.pos + 1'b1;
      if (in_rng && is_at) begin
        if (scan.at_cnt == 2'd0) scan_next.at_off = scan.pos[POS_W-1:0];
        if (scan.at_cnt != 2'd2) scan_next.at_cnt = scan.at_cnt + 1'b1;
      end
    end
    if (nm) begin
      if (s1_byte == CH_SLASH) begin
        if (scan.slash_cnt != 2'd2) scan_next.slash_cnt = scan.slash_cnt + 1'b1;
        if (scan.slash_cnt == 2'd0) begin
          scan_next.slash_pos = scan.pos[POS_W-1:0];
          scan_next.comp0_ok  = comp_accept(scan.cs);
        end else begin
          scan_next.rest_ok = scan.rest_ok && comp_accept(scan.cs);
        end
        scan_next.cs       = C_START;
        scan_next.tag_seen = 1'b0;
        scan_next.tag_cnt  = '0;
        scan_next.tag_bad  = 1'b0;
      end else begin
        scan_next.cs = comp_step(scan.cs, s1_byte);
        if (scan.tag_seen) begin
          if (scan.tag_cnt != TAG_W'(MAX_TAG + 1)) scan_next.tag_cnt = scan.tag_cnt + 1'b1;
          if (scan.tag_cnt == '0) begin
            if (!is_word(s1_byte)) scan_next.tag_bad = 1'b1;
          end else if (!is_word(s1_byte) && s1_byte != CH_DOT && s1_byte != CH_DASH) begin
            scan_next.tag_bad = 1'b1;
          end
        end else if (s1_byte == CH_COLON) begin
          // candidate tag colon: freeze the view of the component that ends here
          scan_next.tag_seen   = 1'b1;
          scan_next.tag_pos    = scan.pos[POS_W-1:0];
          scan_next.snap_ok    = comp_accept(scan.cs);
          scan_next.snap_empty = scan.cs == C_START;
        end
        if (scan.slash_cnt == 2'd0) begin
          if (s1_byte == CH_DOT || s1_byte == CH_COLON) scan_next.pre_dc = 1'b1;
          if (scan.pos < LEN_W'(HOST_CHARS)) begin
            if (s1_byte != local_char(idx9)) scan_next.local_ok = 1'b0;
            if (fold_case(s1_byte) != hub_char(idx9)) scan_next.hub_ok = 1'b0;
          end
          if (s1_byte <= CH_SPACE) scan_next.reg_bad = 1'b1;
          if (scan.reg_colon) begin
            if (scan.port_cnt != PORT_SAT) scan_next.port_cnt = scan.port_cnt + 1'b1;
            if (!is_digit(s1_byte)) scan_next.port_bad = 1'b1;
          end else if (s1_byte == CH_COLON) begin
            scan_next.reg_colon  = 1'b1;
            scan_next.reg_colon0 = scan.pos == '0;
          end
        end
      end
    end
    if (dg) begin
      scan_next.d_any = 1'b1;
      if (!scan.d_colon) begin
        if (s1_byte == CH_COLON) begin
          scan_next.d_colon = 1'b1;
        end else begin
          if (scan.algo_cnt < ALGO_CHARS) begin
            if (s1_byte != algo_char(scan.algo_cnt, 1'b0)) scan_next.m256 = 1'b0;
            if (s1_byte != algo_char(scan.algo_cnt, 1'b1)) scan_next.m512 = 1'b0;
          end
          if (scan.algo_cnt != ALGO_SAT) scan_next.algo_cnt = scan.algo_cnt + 1'b1;
        end
      end else begin
        if (scan.hex_cnt != HEX_SAT) scan_next.hex_cnt = scan.hex_cnt + 1'b1;
        if (!is_lc_hex(s1_byte)) scan_next.hex_bad = 1'b1;
      end
    end
  end

  // verdict from the scan state after the final word
  logic             dom;
  logic             last_ok;
  logic             last_empty;
  logic             path_good;
  logic             reg_fail;
  logic             lib;
  logic [LEN_W-1:0] total;
  logic [LEN_W-1:0] name_end;
  logic [LEN_W-1:0] pstart;
  logic [LEN_W-1:0] plen;
  logic [HEX_W-1:0] hex_want;
  status_t          st;

  always_comb begin
    dom = scan_next.slash_cnt != 2'd0 &&
          (scan_next.pre_dc || (scan_next.slash_pos == HOST_CHARS && scan_next.local_ok));
    last_ok    = scan_next.tag_seen ? scan_next.snap_ok : comp_accept(scan_next.cs);
    last_empty = scan_next.tag_seen ? scan_next.snap_empty : scan_next.cs == C_START;
    if (scan_next.slash_cnt == 2'd0) path_good = last_ok;
    else if (dom) path_good = scan_next.rest_ok && last_ok;
    else path_good = scan_next.comp0_ok && scan_next.rest_ok && last_ok;
    reg_fail = scan_next.reg_bad || (scan_next.reg_colon &&
               (scan_next.reg_colon0 || scan_next.port_cnt == 3'd0 ||
                scan_next.port_cnt > PORT_MAX || scan_next.port_bad));
    lib = (!dom || (scan_next.slash_pos == HOST_CHARS && scan_next.hub_ok)) &&
          !(dom ? scan_next.slash_cnt == 2'd2 : scan_next.slash_cnt != 2'd0);
    total    = (scan_next.at_cnt != 2'd0) ? LEN_W'(scan_next.at_off) : scan_next.pos;
    name_end = scan_next.tag_seen ? LEN_W'(scan_next.tag_pos) : total;
    pstart   = dom ? LEN_W'(scan_next.slash_pos) + 1'b1 : '0;
    plen     = name_end - pstart;
    hex_want = scan_next.m512 ? HEX_SHA512 : HEX_SHA256;

    priority if (scan_next.pos == '0) st = ST_EMPTY;
    else if (scan_next.pos > LEN_W'(MAX_LEN)) st = ST_TOO_LONG;
    else if (scan_next.at_cnt == 2'd2) st = ST_MULTI_AT;
    else if (scan_next.at_cnt == 2'd1 && !scan_next.d_any) st = ST_NO_DIGEST;
    else if (scan_next.at_cnt == 2'd1 && !scan_next.d_colon) st = ST_DIGEST_NO_COLON;
    else if (scan_next.at_cnt == 2'd1 && !(scan_next.algo_cnt == ALGO_CHARS &&
             (scan_next.m256 || scan_next.m512))) st = ST_BAD_ALGO;
    else if (scan_next.at_cnt == 2'd1 && scan_next.hex_cnt != hex_want) st = ST_HEX_COUNT;
    else if (scan_next.at_cnt == 2'd1 && scan_next.hex_bad) st = ST_BAD_HEX;
    else if (scan_next.at_cnt == 2'd1 && scan_next.at_off == '0) st = ST_NO_NAME;
    else if (scan_next.tag_seen && scan_next.tag_cnt == '0) st = ST_EMPTY_TAG;
    else if (scan_next.tag_seen && (scan_next.tag_cnt > TAG_W'(MAX_TAG) ||
             scan_next.tag_bad)) st = ST_BAD_TAG;
    else if (scan_next.tag_seen && scan_next.tag_pos == '0) st = ST_NO_NAME_TAG;
    else if (dom && scan_next.slash_cnt == 2'd1 && last_empty) st = ST_NO_REPO;
    else if (!path_good) st = ST_BAD_PATH;
    else if (dom && reg_fail) st = ST_BAD_REGISTRY;
    else st = ST_OK;

    vd_next        = '0;
    vd_next.status = st;
    if (st == ST_OK) begin
      vd_next.reg_size  = dom ? OUT_W'(scan_next.slash_pos) : '0;
      vd_next.repo_off  = OUT_W'(pstart);
      vd_next.repo_size = OUT_W'(plen);
      if (scan_next.tag_seen) begin
        vd_next.tag_start = OUT_W'(LEN_W'(scan_next.tag_pos) + 1'b1);
        vd_next.tag_len   = SLEN_W'(scan_next.tag_cnt);
      end
      if (scan_next.at_cnt == 2'd1) begin
        vd_next.dgst_off      = OUT_W'(LEN_W'(scan_next.at_off) + 1'b1);
        vd_next.dgst_size     = DIGEST_HEAD + SLEN_W'(scan_next.hex_cnt);
        vd_next.digest_sha512 = scan_next.m512;
      end
      vd_next.add_library_prefix = lib;
      vd_next.implied_tag        = !scan_next.tag_seen && scan_next.at_cnt == 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan     <= scan_init();
      vd_valid <= 1'b0;
    end else begin
      if (s1_adv) scan <= s1_ends ? scan_init() : scan_next;
      if (s1_adv && s1_ends) vd_valid <= 1'b1;
      else if (verdict.ready) vd_valid <= 1'b0;
    end
    if (s1_adv && s1_ends) vd <= vd_next;
  end

  assign verdict.valid              = vd_valid;
  assign verdict.status             = vd.status;
  assign verdict.reg_size           = vd.reg_size;
  assign verdict.repo_off           = vd.repo_off;
  assign verdict.repo_size          = vd.repo_size;
  assign verdict.tag_start          = vd.tag_start;
  assign verdict.tag_len            = vd.tag_len;
  assign verdict.dgst_off           = vd.dgst_off;
  assign verdict.dgst_size          = vd.dgst_size;
  assign verdict.digest_sha512      = vd.digest_sha512;
  assign verdict.add_library_prefix = vd.add_library_prefix;
  assign verdict.implied_tag        = vd.implied_tag;

endmodule
